// File: design/spq_pkg.sv
package spq_pkg;

	localparam int NUM_QUEUES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int MAX_PKT_BYTES   = 9216;

	localparam int TAG_W      = 16;
	localparam int BYTES_W    = 14;
	localparam int PRIO_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int OUTQ_W     = 3;
	localparam int QSEL_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ACTQ_W     = 4;
	localparam int LIMIT_W    = 16;
	localparam int PROD_W     = 30;

	localparam logic [ACTQ_W-1:0]  RST_ACTIVE_QUEUES = 4'd8;
	localparam logic [LIMIT_W-1:0] RST_LIMIT         = 16'd1000;
	localparam logic [BYTES_W-1:0] RST_MEAN          = 14'd1500;
	localparam logic [LIMIT_W-1:0] RST_THRESH        = 16'd65;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQ   = 2'd0,
		ST_DROP  = 2'd1,
		ST_DEQ   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_QUEUES = 3'd0,
		CFG_LIMIT         = 3'd1,
		CFG_MEAN          = 3'd2,
		CFG_THRESH        = 3'd3,
		CFG_MARK_DEQ      = 3'd4,
		CFG_MARK_PRIO     = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic               ce;
		logic               ect;
		logic [BYTES_W-1:0] bytes;
		logic [TAG_W-1:0]   tag;
	} desc_t;

	typedef struct packed {
		logic               en;
		logic               deq;
		logic [QSEL_W-1:0]  q;
		logic [BYTES_W-1:0] bytes;
	} qs_upd_t;

endpackage

// File: design/spq_if.sv
interface spq_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [spq_pkg::TAG_W-1:0]     packet_tag;
	logic [spq_pkg::BYTES_W-1:0]   packet_bytes;
	logic [spq_pkg::PRIO_W-1:0]    class_priority;
	logic                          ecn_capable;
	logic                          congestion_in;

	modport source(output valid, command, packet_tag, packet_bytes, class_priority,
		ecn_capable, congestion_in, input ready);
	modport sink(input valid, command, packet_tag, packet_bytes, class_priority,
		ecn_capable, congestion_in, output ready);
endinterface

interface spq_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [spq_pkg::STATUS_W-1:0]  status;
	logic [spq_pkg::TAG_W-1:0]     out_tag;
	logic [spq_pkg::BYTES_W-1:0]   out_bytes;
	logic [spq_pkg::OUTQ_W-1:0]    out_queue;
	logic                          out_congestion;

	modport source(output valid, status, out_tag, out_bytes, out_queue, out_congestion,
		input ready);
	modport sink(input valid, status, out_tag, out_bytes, out_queue, out_congestion,
		output ready);
endinterface

// File: design/spq_dmem.sv
module spq_dmem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  spq_pkg::desc_t        wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output spq_pkg::desc_t        rdata
);

	spq_pkg::desc_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/spq_qstate.sv
module spq_qstate #(
	parameter int NQ    = 8,
	parameter int DEPTH = 256,
	parameter int QW    = 3,
	parameter int PW    = 8,
	parameter int CNTW  = 9,
	parameter int SW    = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spq_pkg::qs_upd_t       upd,
	output logic [NQ-1:0][PW-1:0]  head,
	output logic [NQ-1:0][PW-1:0]  tail,
	output logic [NQ-1:0]          nonempty,
	output logic [NQ-1:0]          full,
	output logic [NQ-1:0][SW-1:0]  pre
);

	logic [NQ-1:0][PW-1:0]   head_q;
	logic [NQ-1:0][PW-1:0]   tail_q;
	logic [NQ-1:0][CNTW-1:0] cnt_q;
	logic [NQ-1:0][SW-1:0]   pre_q;  // bytes of queues 0..i
	logic [QW-1:0]           qi;

	assign qi = upd.q[QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			pre_q  <= '0;
		end else if (upd.en) begin
			if (upd.deq) begin
				head_q[qi] <= (head_q[qi] == PW'(DEPTH - 1)) ? '0 : head_q[qi] + 1'b1;
				cnt_q[qi]  <= cnt_q[qi] - 1'b1;
			end else begin
				tail_q[qi] <= (tail_q[qi] == PW'(DEPTH - 1)) ? '0 : tail_q[qi] + 1'b1;
				cnt_q[qi]  <= cnt_q[qi] + 1'b1;
			end
			for (int i = 0; i < NQ; i++) begin
				if (i >= int'(qi)) begin
					if (upd.deq) begin
						pre_q[i] <= pre_q[i] - SW'(upd.bytes);
					end else begin
						pre_q[i] <= pre_q[i] + SW'(upd.bytes);
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NQ; i++) begin
			nonempty[i] = (cnt_q[i] != '0);
			full[i]     = (cnt_q[i] >= CNTW'(DEPTH));
		end
	end

	assign head = head_q;
	assign tail = tail_q;
	assign pre  = pre_q;

endmodule

// File: design/strict_priority_queue_ecn_marker_core.sv
// channel | dir | handshake       | payload
// req     | in  | valid/ready     | command, packet_tag, packet_bytes, class_priority,
//         |     |                 | ecn_capable, congestion_in
// rsp     | out | valid/ready     | status, out_tag, out_bytes, out_queue, out_congestion
// cfg     | in  | cfg_we          | cfg_index, cfg_wdata
//
// Stage 1 selects the queue and, for a dequeue, reads the descriptor memory; stage 2
// takes the read data, writes the descriptor of an enqueue and updates queue state.
// A new request is not taken while the previous item is in stage 2.
// Result appears the cycle after stage 2 and holds until taken; req also stalls while
// the result register is full and not being taken. Reset clears all queue state.
module strict_priority_queue_ecn_marker_core #(
	parameter int NUM_QUEUES  = spq_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	spq_req_if.sink                           req,
	spq_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [spq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [spq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW   = $clog2(NUM_QUEUES * QUEUE_DEPTH * spq_pkg::MAX_PKT_BYTES + 1);
	localparam int MD   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW   = $clog2(MD);
	localparam int CW   = (SW + 1 > spq_pkg::PROD_W) ? SW + 1 : spq_pkg::PROD_W;
	localparam int NW   = 5;

	// configuration
	logic [spq_pkg::ACTQ_W-1:0]  act_q;
	logic [spq_pkg::LIMIT_W-1:0] limit_q;
	logic [spq_pkg::BYTES_W-1:0] mean_q;
	logic [spq_pkg::LIMIT_W-1:0] thresh_q;
	logic                        mark_deq_q;
	logic                        mark_prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= spq_pkg::RST_ACTIVE_QUEUES;
			limit_q     <= spq_pkg::RST_LIMIT;
			mean_q      <= spq_pkg::RST_MEAN;
			thresh_q    <= spq_pkg::RST_THRESH;
			mark_deq_q  <= 1'b0;
			mark_prio_q <= 1'b0;
		end else if (cfg_we) begin
			case (spq_pkg::cfg_idx_t'(cfg_index))
				spq_pkg::CFG_ACTIVE_QUEUES: act_q <= cfg_wdata[spq_pkg::ACTQ_W-1:0];
				spq_pkg::CFG_LIMIT:         limit_q <= cfg_wdata;
				spq_pkg::CFG_MEAN:          mean_q <= cfg_wdata[spq_pkg::BYTES_W-1:0];
				spq_pkg::CFG_THRESH:        thresh_q <= cfg_wdata;
				spq_pkg::CFG_MARK_DEQ:      mark_deq_q <= cfg_wdata[0];
				spq_pkg::CFG_MARK_PRIO:     mark_prio_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// queue state
	spq_pkg::qs_upd_t               upd;
	logic [NUM_QUEUES-1:0][PW-1:0]  head;
	logic [NUM_QUEUES-1:0][PW-1:0]  tail;
	logic [NUM_QUEUES-1:0]          nonempty;
	logic [NUM_QUEUES-1:0]          full;
	logic [NUM_QUEUES-1:0][SW-1:0]  pre;

	spq_qstate #(
		.NQ(NUM_QUEUES), .DEPTH(QUEUE_DEPTH), .QW(QW), .PW(PW), .CNTW(CNTW), .SW(SW)
	) u_qstate (
		.clk, .arst_n, .upd, .head, .tail, .nonempty, .full, .pre
	);

	// stage 1: queue select and memory read
	logic           accept;
	logic [NW-1:0]  nq;
	logic [NW-1:0]  last;
	logic [QW-1:0]  q_enq;
	logic [QW-1:0]  q_deq;
	logic           deq_found;
	logic [QW-1:0]  q_sel;
	logic [AW-1:0]  raddr;

	assign accept = req.valid && req.ready;

	always_comb begin
		if (act_q == '0) begin
			nq = NW'(1);
		end else if (NW'(act_q) > NW'(NUM_QUEUES)) begin
			nq = NW'(NUM_QUEUES);
		end else begin
			nq = NW'(act_q);
		end
		last = nq - 1'b1;
		if (spq_pkg::PRIO_W'(nq) <= req.class_priority) begin
			q_enq = last[QW-1:0];
		end else begin
			q_enq = req.class_priority[QW-1:0];
		end
		deq_found = 1'b0;
		q_deq     = '0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (nonempty[i] && (i < int'(nq))) begin
				deq_found = 1'b1;
				q_deq     = QW'(i);
			end
		end
		q_sel = (req.command == spq_pkg::CMD_DEQ) ? q_deq : q_enq;
		raddr = AW'(int'(q_sel) * QUEUE_DEPTH + int'(head[q_sel]));
	end

	logic                        busy_s1;
	logic                        cmd_s1;
	logic [spq_pkg::TAG_W-1:0]   tag_s1;
	logic [spq_pkg::BYTES_W-1:0] bytes_s1;
	logic                        ect_s1;
	logic                        ce_s1;
	logic [QW-1:0]               q_s1;
	logic                        empty_s1;
	logic                        full_s1;
	logic [SW-1:0]               total_s1;
	logic [SW-1:0]               preq_s1;
	logic [spq_pkg::PROD_W-1:0]  limit_s1;
	logic [spq_pkg::PROD_W-1:0]  thresh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.command;
			tag_s1    <= req.packet_tag;
			bytes_s1  <= req.packet_bytes;
			ect_s1    <= req.ecn_capable;
			ce_s1     <= req.congestion_in;
			q_s1      <= q_sel;
			empty_s1  <= !deq_found;
			full_s1   <= full[q_sel];
			total_s1  <= pre[last[QW-1:0]];
			preq_s1   <= pre[q_sel];
			limit_s1  <= spq_pkg::PROD_W'(limit_q) * spq_pkg::PROD_W'(mean_q);
			thresh_s1 <= spq_pkg::PROD_W'(thresh_q) * spq_pkg::PROD_W'(mean_q);
		end
	end

	spq_pkg::desc_t rdata;
	spq_pkg::desc_t wdata;
	logic           we;
	logic [AW-1:0]  waddr;

	spq_dmem #(.DEPTH(MD), .AW(AW)) u_dmem (
		.clk, .we, .waddr, .wdata,
		.re(accept && (req.command == spq_pkg::CMD_DEQ)), .raddr, .rdata
	);

	// stage 2: decide, write back, build result
	spq_pkg::status_t            res_status;
	logic [spq_pkg::TAG_W-1:0]   res_tag;
	logic [spq_pkg::BYTES_W-1:0] res_bytes;
	logic [spq_pkg::OUTQ_W-1:0]  res_queue;
	logic                        res_ce;
	logic [CW-1:0]               ref_enq;
	logic [CW-1:0]               ref_deq;
	logic                        drop;

	always_comb begin
		ref_enq = CW'(mark_prio_q ? preq_s1 : total_s1) + CW'(bytes_s1);
		ref_deq = CW'(mark_prio_q ? preq_s1 : total_s1) - CW'(rdata.bytes);
		drop    = (CW'(total_s1) + CW'(bytes_s1) > CW'(limit_s1)) || full_s1;
		upd     = '0;
		we      = 1'b0;
		waddr   = AW'(int'(q_s1) * QUEUE_DEPTH + int'(tail[q_s1]));
		wdata.tag   = tag_s1;
		wdata.bytes = bytes_s1;
		wdata.ect   = ect_s1;
		wdata.ce    = ce_s1 ||
			(ect_s1 && !mark_deq_q && (ref_enq > CW'(thresh_s1)));
		res_tag   = tag_s1;
		res_bytes = bytes_s1;
		res_queue = spq_pkg::OUTQ_W'(q_s1);
		res_ce    = ce_s1;
		if (cmd_s1 == spq_pkg::CMD_ENQ) begin
			if (drop) begin
				res_status = spq_pkg::ST_DROP;
			end else begin
				res_status = spq_pkg::ST_ENQ;
				res_ce     = wdata.ce;
				we         = busy_s1;
				upd.en     = busy_s1;
				upd.q      = spq_pkg::QSEL_W'(q_s1);
				upd.bytes  = bytes_s1;
			end
		end else if (empty_s1) begin
			res_status = spq_pkg::ST_EMPTY;
			res_tag    = '0;
			res_bytes  = '0;
			res_queue  = '0;
			res_ce     = 1'b0;
		end else begin
			res_status = spq_pkg::ST_DEQ;
			res_tag    = rdata.tag;
			res_bytes  = rdata.bytes;
			res_ce     = rdata.ce ||
				(rdata.ect && mark_deq_q && (ref_deq > CW'(thresh_s1)));
			upd.en     = busy_s1;
			upd.deq    = 1'b1;
			upd.q      = spq_pkg::QSEL_W'(q_s1);
			upd.bytes  = rdata.bytes;
		end
	end

	// result register
	logic                        rsp_valid_q;
	logic [spq_pkg::STATUS_W-1:0] status_q;
	logic [spq_pkg::TAG_W-1:0]   tag_q;
	logic [spq_pkg::BYTES_W-1:0] bytes_q;
	logic [spq_pkg::OUTQ_W-1:0]  queue_q;
	logic                        ce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (busy_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			status_q <= res_status;
			tag_q    <= res_tag;
			bytes_q  <= res_bytes;
			queue_q  <= res_queue;
			ce_q     <= res_ce;
		end
	end

	assign req.ready          = !busy_s1 && (!rsp_valid_q || rsp.ready);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.out_tag        = tag_q;
	assign rsp.out_bytes      = bytes_q;
	assign rsp.out_queue      = queue_q;
	assign rsp.out_congestion = ce_q;

endmodule

// File: design/spq_checker.sv
module spq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [spq_pkg::STATUS_W-1:0]      status,
	input logic [spq_pkg::TAG_W-1:0]         out_tag,
	input logic [spq_pkg::BYTES_W-1:0]       out_bytes,
	input logic [spq_pkg::OUTQ_W-1:0]        out_queue,
	input logic                              out_congestion
);

	a_one_per_two: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("item accepted on back-to-back cycles");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> ##1 rsp_valid)
		else $error("no result two cycles after accept");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status == spq_pkg::ST_EMPTY)) |->
		(out_tag == '0 && out_bytes == '0 && out_queue == '0 && !out_congestion))
		else $error("empty result carries data");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(out_tag)))
		else $error("stalled result changed");

endmodule

bind strict_priority_queue_ecn_marker_core spq_checker u_spq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.out_tag(rsp.out_tag),
	.out_bytes(rsp.out_bytes),
	.out_queue(rsp.out_queue),
	.out_congestion(rsp.out_congestion)
);
